@@ rtl/sps_pkg.sv @@
// Package for the serial port shift unit: field widths, access kinds, bus addresses,
// countdown reload values and the item types shared by the modules.
// Depends on nothing.
package sps_pkg;

   // Field widths.
   localparam int KIND_W = 2;
   localparam int ADDR_W = 16;
   localparam int DATA_W = 8;
   localparam int TICK_W = 10;
   localparam int BITS_W = 4;

   // Access kinds carried in the kind field.
   localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

   // Register addresses on the bus.
   localparam logic [ADDR_W-1:0] DATA_ADDR = 16'hFF01;
   localparam logic [ADDR_W-1:0] CTRL_ADDR = 16'hFF02;

   // Countdown lengths for one bit, reduced to the countdown width.
   localparam int NORMAL_TICKS = 512;
   localparam int FAST_TICKS   = 16;
   localparam logic [TICK_W-1:0] NORMAL_RELOAD = TICK_W'(NORMAL_TICKS % (1 << TICK_W));
   localparam logic [TICK_W-1:0] FAST_RELOAD   = TICK_W'(FAST_TICKS % (1 << TICK_W));

   // Bits shifted in one transfer.
   localparam logic [BITS_W-1:0] XFER_BITS = 4'd8;

   // Control register bit positions.
   localparam int CTRL_SOURCE_BIT = 0;
   localparam int CTRL_SPEED_BIT  = 1;
   localparam int CTRL_START_BIT  = 7;

   // One input item.
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [ADDR_W-1:0] address;
      logic [DATA_W-1:0] write_data;
   } sps_req_type;

   // One result item.
   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic              irq_request;
   } sps_rsp_type;

endpackage

@@ rtl/sps_if.sv @@
// Valid/ready channel interfaces for the request and response items.
// Depends on sps_pkg.
interface sps_req_if;
   import sps_pkg::*;

   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [ADDR_W-1:0] address;
   logic [DATA_W-1:0] write_data;

   modport source (output valid, output kind, output address, output write_data,
                   input ready);
   modport sink (input valid, input kind, input address, input write_data,
                 output ready);
endinterface

interface sps_rsp_if;
   import sps_pkg::*;

   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] read_data;
   logic              irq_request;

   modport source (output valid, output read_data, output irq_request, input ready);
   modport sink (input valid, input read_data, input irq_request, output ready);
endinterface

@@ rtl/sps_core.sv @@
// Register state of the serial port and the single-pass logic that applies one item.
// Depends on sps_pkg.
module sps_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                enable,
   input  sps_pkg::sps_req_type item,
   output sps_pkg::sps_rsp_type result
);
   import sps_pkg::*;

   logic [DATA_W-1:0] shift_byte_ff, shift_byte_in;
   logic [BITS_W-1:0] bits_left_ff, bits_left_in;
   logic              busy_ff, busy_in;
   logic [TICK_W-1:0] tick_countdown_ff, tick_countdown_in;
   logic              fast_speed_ff, fast_speed_in;
   logic              internal_source_ff, internal_source_in;

   logic [TICK_W-1:0] count_dec;
   logic [BITS_W-1:0] bits_dec;
   logic              start_write;

   assign count_dec   = tick_countdown_ff - 1'b1;
   assign bits_dec    = bits_left_ff - 1'b1;
   assign start_write = item.write_data[CTRL_SOURCE_BIT] & item.write_data[CTRL_START_BIT];

   // Next state and result for the item in the input register.
   always_comb begin
      shift_byte_in      = shift_byte_ff;
      bits_left_in       = bits_left_ff;
      busy_in            = busy_ff;
      tick_countdown_in  = tick_countdown_ff;
      fast_speed_in      = fast_speed_ff;
      internal_source_in = internal_source_ff;
      result             = '0;
      if (enable) begin
         case (item.kind)
            KIND_TICK: begin
               // A tick counts down only during a transfer; expiry shifts in a one.
               if (busy_ff && (tick_countdown_ff != '0)) begin
                  tick_countdown_in = count_dec;
                  if (count_dec == '0) begin
                     shift_byte_in = {shift_byte_ff[DATA_W-2:0], 1'b1};
                     bits_left_in  = bits_dec;
                     if (bits_dec == '0) begin
                        busy_in            = 1'b0;
                        result.irq_request = 1'b1;
                     end else begin
                        tick_countdown_in = fast_speed_ff ? FAST_RELOAD : NORMAL_RELOAD;
                     end
                  end
               end
            end
            KIND_WRITE: begin
               if (item.address == DATA_ADDR) begin
                  shift_byte_in = item.write_data;
               end else if ((item.address == CTRL_ADDR) && start_write) begin
                  // A start with the internal clock (re)loads the transfer.
                  bits_left_in       = XFER_BITS;
                  busy_in            = 1'b1;
                  fast_speed_in      = item.write_data[CTRL_SPEED_BIT];
                  internal_source_in = 1'b1;
                  tick_countdown_in  = item.write_data[CTRL_SPEED_BIT] ? FAST_RELOAD
                                                                       : NORMAL_RELOAD;
               end
            end
            KIND_READ: begin
               if (item.address == DATA_ADDR) begin
                  result.read_data = shift_byte_ff;
               end else if (item.address == CTRL_ADDR) begin
                  result.read_data[CTRL_START_BIT]  = busy_ff;
                  result.read_data[CTRL_SPEED_BIT]  = fast_speed_ff;
                  result.read_data[CTRL_SOURCE_BIT] = internal_source_ff;
               end
            end
            default: begin
               // The unused kind leaves the state alone and returns zeros.
               result = '0;
            end
         endcase
      end
   end

   // Port state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         shift_byte_ff      <= '0;
         bits_left_ff       <= '0;
         busy_ff            <= 1'b0;
         tick_countdown_ff  <= '0;
         fast_speed_ff      <= 1'b0;
         internal_source_ff <= 1'b0;
      end else begin
         shift_byte_ff      <= shift_byte_in;
         bits_left_ff       <= bits_left_in;
         busy_ff            <= busy_in;
         tick_countdown_ff  <= tick_countdown_in;
         fast_speed_ff      <= fast_speed_in;
         internal_source_ff <= internal_source_in;
      end
   end

endmodule

@@ rtl/serial_port_shift_unit_top.sv @@
// An accepted item waits in the input register, then moves to the result register when that
// register is free or being taken, and is held there until the consumer takes it.
// Throughput: one item per cycle when not stalled; each item's state update is one sps_core pass.
// While a result waits, the input register still takes one more item, then the input stalls.
// Reset (synchronous, active high) clears both valid flags and the port state to idle.
// Depends on sps_pkg, sps_if and sps_core.
module serial_port_shift_unit_top (
   input  logic clock,
   input  logic reset,
   sps_req_if.sink   req_bus,
   sps_rsp_if.source rsp_bus
);
   import sps_pkg::*;

   logic        in_valid_ff, in_valid_in;
   sps_req_type in_item_ff, in_item_in;
   logic        out_valid_ff, out_valid_in;
   sps_rsp_type out_rsp_ff, out_rsp_in;

   logic        advance;
   logic        req_fire;
   sps_rsp_type core_rsp;

   // The input register moves forward when the result register is free or being taken.
   assign advance       = !out_valid_ff || rsp_bus.ready;
   assign req_bus.ready = !in_valid_ff || advance;
   assign req_fire      = req_bus.valid && req_bus.ready;

   sps_core u_core (
      .clock  (clock),
      .reset  (reset),
      .enable (in_valid_ff && advance),
      .item   (in_item_ff),
      .result (core_rsp)
   );

   // Next values of the two stage registers.
   always_comb begin
      in_valid_in  = in_valid_ff;
      in_item_in   = in_item_ff;
      out_valid_in = out_valid_ff;
      out_rsp_in   = out_rsp_ff;
      if (advance) begin
         out_valid_in = in_valid_ff;
         out_rsp_in   = core_rsp;
         in_valid_in  = 1'b0;
      end
      if (req_fire) begin
         in_valid_in           = 1'b1;
         in_item_in.kind       = req_bus.kind;
         in_item_in.address    = req_bus.address;
         in_item_in.write_data = req_bus.write_data;
      end
   end

   // Valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
      out_rsp_ff <= out_rsp_in;
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.read_data   = out_rsp_ff.read_data;
   assign rsp_bus.irq_request = out_rsp_ff.irq_request;

endmodule

@@ rtl/sps_checker.sv @@
// Port-level checks for the serial port shift unit, bound to the top level.
// Depends on sps_pkg and serial_port_shift_unit_top.
module sps_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [sps_pkg::DATA_W-1:0] rsp_read_data,
   input logic                      rsp_irq_request
);
   import sps_pkg::*;

   // Reset leaves no result pending.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // An empty result register never holds back the input side.
   assert property (@(posedge clock) disable iff (reset) !rsp_valid |-> req_ready)
      else $error("input stalled with the result register empty");

   // An interrupt comes only from a tick, which never returns read data.
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_valid && rsp_irq_request) |-> (rsp_read_data == '0))
      else $error("interrupt item carries read data");

   // A result that appears on an empty output comes from an accepted item that passed the input register.
   assert property (@(posedge clock) disable iff (reset)
                    (!rsp_valid ##1 rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result appeared without an accepted item");

   // A stalled result holds its payload.
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_valid && !rsp_ready) |=>
                    (rsp_valid && $stable(rsp_read_data) && $stable(rsp_irq_request)))
      else $error("stalled result changed");

endmodule

bind serial_port_shift_unit_top sps_checker u_sps_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_read_data   (rsp_bus.read_data),
   .rsp_irq_request (rsp_bus.irq_request)
);
